[rtl/rhc_pkg.sv]
package rhc_pkg;

  // Default channel width in bits
  localparam int unsigned ChannelBitsDefault = 8;

  // Hue is in 1/64 degree: one sixth of a turn is 60 degrees
  localparam int unsigned HueW         = 15;
  localparam int unsigned HueSixth     = 3840;
  localparam int unsigned HueGreenOfs  = 7680;
  localparam int unsigned HueBlueOfs   = 15360;
  localparam int unsigned HueTurn      = 23040;

  // Quotient bits of the hue division: 3840 * |diff| / c never exceeds 3840
  localparam int unsigned HueQuoBits   = 12;

  // Hue sector, picked by the first channel that equals the maximum
  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

endpackage

[rtl/rhc_pix_if.sv]
interface rhc_pix_if #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::ChannelBitsDefault
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::ChannelBitsDefault
);
  import rhc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [HueW-1:0]         hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

[rtl/rgb_to_hsv_converter_core.sv]
// RGB to HSV pixel converter.
//
// pix_i takes one pixel (red, green, blue) per request on a valid/ready
// handshake; hsv_o returns hue (1/64 degree, 0..23039), saturation
// (255 * chroma / value, scaled to the channel width) and brightness (the
// largest channel). Every request gives exactly one result, in order.
//
// Throughput: one pixel per cycle, sustained while hsv_o.ready stays high.
// The result passes through stage A, stage B, the divider stages of the two
// restoring dividers, which retire one quotient bit per pipeline stage, and
// the output register before it reaches hsv_o.
//
// Reset clears every valid bit; the pipeline comes up empty and ready.
// When the receiver stalls, the held result stays on hsv_o and one more
// result drops into a skid register; the pipeline then freezes as a whole
// and pix_i.ready falls until the skid register drains. Nothing is lost or
// repeated.
module rgb_to_hsv_converter_core #(
  parameter int unsigned CHANNEL_BITS = rhc_pkg::ChannelBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhc_pix_if.sink   pix_i,
  rhc_hsv_if.source hsv_o
);
  import rhc_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned QW = (CB > HueQuoBits) ? CB : HueQuoBits;
  localparam int unsigned RW = CB + QW;
  localparam logic [CB-1:0] MaxV = {CB{1'b1}};

  typedef struct packed {
    logic [CB-1:0] v;
    logic [CB-1:0] c;
    logic [CB-1:0] dmag;
    logic          neg;
    sector_e       sec;
  } sa_t;

  typedef struct packed {
    logic [RW-1:0] rs;
    logic [RW-1:0] rh;
    logic [QW-1:0] qs;
    logic [QW-1:0] qh;
    logic [CB-1:0] v;
    logic [CB-1:0] c;
    logic          neg;
    sector_e       sec;
  } dv_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [CB-1:0]   sat;
    logic [CB-1:0]   v;
  } res_t;

  logic          en;
  logic          sa_vld_q;
  sa_t           sa_d, sa_q;
  logic [QW:0]   dv_vld_q;
  dv_t           dv_d  [QW+1];
  dv_t           dv_q  [QW+1];
  res_t          fin;
  logic          fin_vld;
  res_t          out_q, sk_q;
  logic          ovld_q, skv_q;

  // Freeze the whole pipeline while the skid register is full
  assign en          = ~skv_q;
  assign pix_i.ready = en;

  // Stage A: maximum, minimum, chroma, sector and signed difference
  always_comb begin
    logic [CB-1:0] r, g, b, mx, mn, da, db;
    logic [CB:0]   diff;
    r  = pix_i.red;
    g  = pix_i.green;
    b  = pix_i.blue;
    mx = (g > r) ? g : r;
    mx = (b > mx) ? b : mx;
    mn = (g < r) ? g : r;
    mn = (b < mn) ? b : mn;
    if (r == mx) begin
      sa_d.sec = SecRed;
      da = g;
      db = b;
    end else if (g == mx) begin
      sa_d.sec = SecGreen;
      da = b;
      db = r;
    end else begin
      sa_d.sec = SecBlue;
      da = r;
      db = g;
    end
    diff      = {1'b0, da} - {1'b0, db};
    sa_d.v    = mx;
    sa_d.c    = mx - mn;
    sa_d.neg  = diff[CB];
    sa_d.dmag = diff[CB] ? CB'(-diff) : diff[CB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q <= sa_d;
    end
  end

  // Stage B: numerators of both divisions
  always_comb begin
    dv_d[0].rs  = (RW'(sa_q.c) << CB) - RW'(sa_q.c);
    dv_d[0].rh  = RW'(sa_q.dmag) * RW'(HueSixth);
    dv_d[0].qs  = '0;
    dv_d[0].qh  = '0;
    dv_d[0].v   = sa_q.v;
    dv_d[0].c   = sa_q.c;
    dv_d[0].neg = sa_q.neg;
    dv_d[0].sec = sa_q.sec;
  end

  // Divider stages: one quotient bit of each division per stage, MSB first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int unsigned Bit = QW - k;
    always_comb begin
      logic [RW-1:0] ts, th;
      ts       = RW'(dv_q[k-1].v) << Bit;
      th       = RW'(dv_q[k-1].c) << Bit;
      dv_d[k]  = dv_q[k-1];
      if (dv_q[k-1].rs >= ts) begin
        dv_d[k].rs      = dv_q[k-1].rs - ts;
        dv_d[k].qs[Bit] = 1'b1;
      end
      if (dv_q[k-1].rh >= th) begin
        dv_d[k].rh      = dv_q[k-1].rh - th;
        dv_d[k].qh[Bit] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k <= QW; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k] <= (k == 0) ? sa_vld_q : dv_vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // Final assembly: sector offset, red wrap, gray and black cases
  always_comb begin
    logic [HueW-1:0] q;
    q = HueW'(dv_q[QW].qh);
    if (dv_q[QW].c == '0) begin
      fin.hue = '0;
    end else begin
      case (dv_q[QW].sec)
        SecRed:   fin.hue = (dv_q[QW].neg && (q != '0)) ? HueW'(HueTurn) - q : q;
        SecGreen: fin.hue = dv_q[QW].neg ? HueW'(HueGreenOfs) - q : HueW'(HueGreenOfs) + q;
        SecBlue:  fin.hue = dv_q[QW].neg ? HueW'(HueBlueOfs) - q : HueW'(HueBlueOfs) + q;
        default:  fin.hue = '0;
      endcase
    end
    fin.sat = (dv_q[QW].v == '0) ? '0 : CB'(dv_q[QW].qs);
    fin.v   = dv_q[QW].v;
  end

  assign fin_vld = dv_vld_q[QW] & en;

  // Output register with skid: catch the result leaving the pipe on a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      skv_q  <= 1'b0;
    end else if (!ovld_q || hsv_o.ready) begin
      ovld_q <= skv_q | fin_vld;
      skv_q  <= 1'b0;
    end else if (fin_vld) begin
      skv_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ovld_q || hsv_o.ready) begin
      out_q <= skv_q ? sk_q : fin;
    end else if (fin_vld) begin
      sk_q  <= fin;
    end
  end

  assign hsv_o.valid      = ovld_q;
  assign hsv_o.hue        = out_q.hue;
  assign hsv_o.saturation = out_q.sat;
  assign hsv_o.brightness = out_q.v;

  // Skid register is only ever full behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni) skv_q |-> ovld_q)
    else $error("skid full without a held result");

  // Skid fills only when the receiver stalled a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skv_q) |-> $past(ovld_q && !hsv_o.ready))
    else $error("skid filled without a stall");

  // Hue stays within one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.hue < HueW'(HueTurn)))
    else $error("hue out of range");

  // Black pixel has neither hue nor saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && (hsv_o.brightness == '0)) |->
      ((hsv_o.saturation == '0) && (hsv_o.hue == '0)))
    else $error("black pixel with hue or saturation");

  // Saturation at most full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.saturation <= MaxV))
    else $error("saturation above full scale");

endmodule
